### design/csc_pkg.sv
package csc_pkg;

  localparam int unsigned SumWidth = 32;
  localparam int unsigned PosWidth = 16;
  localparam int unsigned OutWidth = 32;
  localparam int unsigned OpWidth = 3;
  localparam int unsigned LenWidth = 28;
  localparam int unsigned QueueDepth = 2;

  localparam logic [OpWidth-1:0] OP_M = 3'd0;
  localparam logic [OpWidth-1:0] OP_D = 3'd2;
  localparam logic [OpWidth-1:0] OP_S = 3'd4;
  localparam logic [OpWidth-1:0] OP_H = 3'd5;

  localparam logic [1:0] CLIPS_NONE = 2'd0;
  localparam logic [1:0] CLIPS_ONE = 2'd1;
  localparam logic [1:0] CLIPS_TWO = 2'd2;
  localparam logic [1:0] CLIPS_MANY = 2'd3;

  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};
  localparam logic [SumWidth-1:0] SumMax = {SumWidth{1'b1}};

  typedef struct packed {
    logic [1:0]          clip_count;
    logic                error_seen;
    logic [OpWidth-1:0]  first_op;
    logic [OpWidth-1:0]  second_op;
    logic                match_seen;
    logic [PosWidth-1:0] first_clip_pos;
    logic [PosWidth-1:0] first_match_pos;
    logic [SumWidth-1:0] match_sum;
    logic [SumWidth-1:0] delete_sum;
    logic [SumWidth-1:0] gap_sum;
    logic [SumWidth-1:0] clip_len0;
    logic [SumWidth-1:0] clip_len1;
  } csc_rec_t;

  function automatic logic [SumWidth-1:0] sat_add(input logic [SumWidth-1:0] a,
                                                  input logic [SumWidth-1:0] b);
    logic [SumWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumWidth] ? SumMax : s[SumWidth-1:0];
  endfunction

endpackage

### design/csc_front.sv
module csc_front
  import csc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpWidth-1:0]  cigar_op_i,
  input  logic [LenWidth-1:0] op_length_i,
  input  logic                last_op_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output csc_rec_t            rec_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  csc_rec_t            acc_q, acc_d;
  logic [SumWidth-1:0] len;
  logic                accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign len        = SumWidth'(op_length_i);

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    if (pos_q == '0) begin
      acc_d.first_op = cigar_op_i;
    end
    if (pos_q == PosWidth'(1)) begin
      acc_d.second_op = cigar_op_i;
    end
    if (acc_q.clip_count != CLIPS_NONE && !acc_q.match_seen) begin
      acc_d.gap_sum = sat_add(acc_q.gap_sum, len);
    end
    if (cigar_op_i == OP_S) begin
      unique case (acc_q.clip_count)
        CLIPS_NONE: begin
          acc_d.first_clip_pos = pos_q;
          acc_d.clip_len0      = len;
          acc_d.clip_count     = CLIPS_ONE;
        end
        CLIPS_ONE: begin
          acc_d.clip_len1  = len;
          acc_d.clip_count = CLIPS_TWO;
        end
        default: begin
          acc_d.clip_count = CLIPS_MANY;
          acc_d.error_seen = 1'b1;
        end
      endcase
    end else if (cigar_op_i == OP_M) begin
      acc_d.match_sum = sat_add(acc_q.match_sum, len);
      if (!acc_q.match_seen) begin
        acc_d.match_seen      = 1'b1;
        acc_d.first_match_pos = pos_q;
      end
    end else if (cigar_op_i == OP_D) begin
      acc_d.delete_sum = sat_add(acc_q.delete_sum, len);
    end
    if (pos_q != PosMax) begin
      pos_d = pos_q + PosWidth'(1);
    end
  end

  assign rec_o  = acc_d;
  assign push_o = accept & last_op_i & (acc_d.clip_count != CLIPS_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else if (accept) begin
      if (last_op_i) begin
        acc_q <= '0;
        pos_q <= '0;
      end else begin
        acc_q <= acc_d;
        pos_q <= pos_d;
      end
    end
  end

endmodule

### design/csc_queue.sv
module csc_queue
  import csc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     push_ready_o,
  input  csc_rec_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_i,
  output csc_rec_t pop_data_o
);

  localparam int unsigned PtrWidth = $clog2(QueueDepth);

  csc_rec_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrWidth:0]       count_q;

  assign push_ready_o = count_q != (PtrWidth+1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrWidth+1)'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - (PtrWidth+1)'(1);
      end
    end
  end

endmodule

### design/csc_back.sv
module csc_back
  import csc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  output logic                rec_pop_o,
  input  csc_rec_t            rec_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutWidth-1:0] left_clip_len_o,
  output logic [OutWidth-1:0] left_offset_o,
  output logic                left_offset_valid_o,
  output logic [OutWidth-1:0] match_total_o,
  output logic [OutWidth-1:0] right_offset_o,
  output logic                right_offset_valid_o,
  output logic [OutWidth-1:0] right_clip_len_o,
  output logic                too_many_clips_o,
  output logic [OutWidth-1:0] record_index_o
);

  logic                out_valid_q;
  logic [OutWidth-1:0] rec_cnt_q;
  logic [SumWidth-1:0] lclip, loff, roff, rclip, left_val, right_val;
  logic                lvalid, rvalid, at_left, gap_ok;
  logic [OutWidth-1:0] lclip_q, loff_q, match_q, roff_q, rclip_q, index_q;
  logic                lvalid_q, rvalid_q, err_q;

  assign rec_pop_o = rec_valid_i & (~out_valid_q | out_ready_i);

  assign gap_ok    = rec_i.match_seen &
                     (({1'b0, rec_i.first_clip_pos} + (PosWidth+1)'(1)) <
                      {1'b0, rec_i.first_match_pos});
  assign left_val  = gap_ok ? rec_i.gap_sum : '0;
  assign right_val = sat_add(rec_i.match_sum, rec_i.delete_sum);
  assign at_left   = (rec_i.first_op == OP_S) ||
                     (rec_i.second_op == OP_S && rec_i.first_op == OP_H);

  always_comb begin
    lclip  = '0;
    loff   = '0;
    roff   = '0;
    rclip  = '0;
    lvalid = 1'b0;
    rvalid = 1'b0;
    if (rec_i.match_sum == '0) begin
      lvalid = 1'b0;
    end else if (rec_i.clip_count == CLIPS_ONE) begin
      if (at_left) begin
        lclip  = rec_i.clip_len0;
        loff   = left_val;
        lvalid = 1'b1;
      end else begin
        rclip  = rec_i.clip_len0;
        roff   = right_val;
        rvalid = 1'b1;
      end
    end else begin
      lclip  = rec_i.clip_len0;
      rclip  = rec_i.clip_len1;
      loff   = left_val;
      roff   = right_val;
      lvalid = 1'b1;
      rvalid = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      lclip_q  <= OutWidth'(lclip);
      loff_q   <= OutWidth'(loff);
      lvalid_q <= lvalid;
      match_q  <= OutWidth'(rec_i.match_sum);
      roff_q   <= OutWidth'(roff);
      rvalid_q <= rvalid;
      rclip_q  <= OutWidth'(rclip);
      err_q    <= rec_i.error_seen;
      index_q  <= rec_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rec_cnt_q   <= '0;
    end else begin
      if (rec_pop_o) begin
        out_valid_q <= 1'b1;
        rec_cnt_q   <= rec_cnt_q + OutWidth'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign left_clip_len_o      = lclip_q;
  assign left_offset_o        = loff_q;
  assign left_offset_valid_o  = lvalid_q;
  assign match_total_o        = match_q;
  assign right_offset_o       = roff_q;
  assign right_offset_valid_o = rvalid_q;
  assign right_clip_len_o     = rclip_q;
  assign too_many_clips_o     = err_q;
  assign record_index_o       = index_q;

endmodule

### design/cigar_soft_clip_decoder.sv
// CIGAR soft-clip decoder.
// The input channel carries one CIGAR operation per item (op code, length and a
// last-op mark); the output channel carries one summary item per record that
// holds at least one soft clip. Records without a soft clip produce nothing.
// An operation is accepted every cycle while in_ready_o is high; the front end
// updates the running sums of the record in the accepting cycle.
// On the last operation of a clipped record the totals enter a two-entry queue,
// and the back end moves the queue head into the output register whenever that
// register is empty or is being read by the receiver.
// Sustained throughput is one operation per cycle while the queue has a free
// entry and so in_ready_o is high.
// When the receiver stalls, the output register and the queue hold up to three
// results before in_ready_o falls; no item is lost or repeated.
// Reset clears the running sums, the queue, the output valid flag and the
// record index counter, which wraps after 2^32 results.
module cigar_soft_clip_decoder
  import csc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpWidth-1:0]  cigar_op_i,
  input  logic [LenWidth-1:0] op_length_i,
  input  logic                last_op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutWidth-1:0] left_clip_len_o,
  output logic [OutWidth-1:0] left_offset_o,
  output logic                left_offset_valid_o,
  output logic [OutWidth-1:0] match_total_o,
  output logic [OutWidth-1:0] right_offset_o,
  output logic                right_offset_valid_o,
  output logic [OutWidth-1:0] right_clip_len_o,
  output logic                too_many_clips_o,
  output logic [OutWidth-1:0] record_index_o
);

  logic     push, push_ready, head_valid, pop;
  csc_rec_t push_rec, head_rec;

  csc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cigar_op_i   (cigar_op_i),
    .op_length_i  (op_length_i),
    .last_op_i    (last_op_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .rec_o        (push_rec)
  );

  csc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_rec),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_data_o   (head_rec)
  );

  csc_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .rec_valid_i          (head_valid),
    .rec_pop_o            (pop),
    .rec_i                (head_rec),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .left_clip_len_o      (left_clip_len_o),
    .left_offset_o        (left_offset_o),
    .left_offset_valid_o  (left_offset_valid_o),
    .match_total_o        (match_total_o),
    .right_offset_o       (right_offset_o),
    .right_offset_valid_o (right_offset_valid_o),
    .right_clip_len_o     (right_clip_len_o),
    .too_many_clips_o     (too_many_clips_o),
    .record_index_o       (record_index_o)
  );

endmodule
